FILE: src/sha1_pkg.sv
package sha1_pkg;

	// Input queue between the front and the back.
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Kind codes carried on the input tuser.
	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	// Chaining value after reset, word 0 in the lowest bits.
	localparam logic [4:0][31:0] H_INIT = {
		32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
	};

	// Round constants, one per group of twenty rounds.
	localparam logic [31:0] K_R0 = 32'h5a827999;
	localparam logic [31:0] K_R1 = 32'h6ed9eba1;
	localparam logic [31:0] K_R2 = 32'h8f1bbcdc;
	localparam logic [31:0] K_R3 = 32'hca62c1d6;

	localparam logic [6:0] LAST_ROUND = 7'd79;

	// Padding.
	localparam logic [7:0] PAD_BYTE    = 8'h80;
	localparam logic [5:0] PAD_LEN_POS = 6'd56;
	localparam logic [5:0] BLOCK_END   = 6'd63;

	// Digest words and output beat layout.
	localparam logic [2:0] LAST_WORD_NUM = 3'd4;
	localparam int unsigned OUT_TDATA_W  = 40;

	// One classified item in the queue.
	typedef struct packed {
		logic       finish;
		logic [7:0] data;
	} item_t;

	// Commands from the sequencer to the compression core.
	typedef struct packed {
		logic       absorb;
		logic [7:0] byte_val;
		logic       start;
		logic       reinit;
	} core_cmd_t;

	// Status from the compression core.
	typedef struct packed {
		logic busy;
		logic done;
	} core_stat_t;

endpackage

FILE: src/sha1_front.sv
module sha1_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [7:0]          s_axis_tdata,   // data_byte
	input  logic                s_axis_tuser,   // kind
	output logic                item_valid,
	input  logic                item_ready,
	output sha1_pkg::item_t     item
);
	import sha1_pkg::*;

	item_t               mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                push;
	logic                pop;
	item_t               in_item;

	// Classify the beat; the data byte is dropped on a finish.
	always_comb begin
		in_item.finish = (s_axis_tuser == KIND_FINISH);
		in_item.data   = in_item.finish ? 8'h00 : s_axis_tdata;
	end

	assign s_axis_tready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign item_valid    = (count_q != '0);
	assign item          = mem_q[rd_ptr_q];
	assign push          = s_axis_tvalid && s_axis_tready;
	assign pop           = item_valid && item_ready;

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// The fill count never passes the queue depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("input queue overfilled");

endmodule

FILE: src/sha1_core.sv
module sha1_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sha1_pkg::core_cmd_t     cmd,
	output sha1_pkg::core_stat_t    stat,
	output logic [4:0][31:0]        chain
);
	import sha1_pkg::*;

	logic [4:0][31:0]  chain_q;
	logic [15:0][31:0] w_q;
	logic [31:0]       a_q, b_q, c_q, d_q, e_q;
	logic [6:0]        round_q;
	logic              run_q;
	logic              fin_q;
	logic [31:0]       f_val;
	logic [31:0]       k_val;
	logic [31:0]       t_val;
	logic [31:0]       w_mix;

	assign chain     = chain_q;
	assign stat.busy = run_q || fin_q;
	assign stat.done = fin_q;

	// Round function and constant for the current round.
	always_comb begin
		if (round_q < 7'd20) begin
			f_val = (b_q & c_q) | (~b_q & d_q);
			k_val = K_R0;
		end else if (round_q < 7'd40) begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K_R1;
		end else if (round_q < 7'd60) begin
			f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k_val = K_R2;
		end else begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K_R3;
		end
		t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + k_val + w_q[0];
		w_mix = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
	end

	// Message window: bytes shift in during intake, words shift during rounds.
	always_ff @(posedge clk) begin
		if (cmd.absorb) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
			end
			w_q[15] <= {w_q[15][23:0], cmd.byte_val};
		end else if (run_q) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= {w_mix[30:0], w_mix[31]};
		end
	end

	// Working variables.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (run_q) begin
			a_q <= t_val;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	// Round counter, final add and chaining words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= H_INIT;
			round_q <= '0;
			run_q   <= 1'b0;
			fin_q   <= 1'b0;
		end else begin
			fin_q <= !cmd.start && run_q && (round_q == LAST_ROUND);
			if (cmd.start) begin
				round_q <= '0;
				run_q   <= 1'b1;
			end else if (run_q) begin
				round_q <= round_q + 1'b1;
				if (round_q == LAST_ROUND) begin
					run_q <= 1'b0;
				end
			end
			if (cmd.reinit) begin
				chain_q <= H_INIT;
			end else if (fin_q) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
				chain_q[4] <= chain_q[4] + e_q;
			end
		end
	end

	// A block is started only when the core is free.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !run_q && !fin_q)
		else $error("compression started while busy");

	// No byte enters the window while rounds are running.
	assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> !cmd.absorb)
		else $error("byte absorbed during compression");

endmodule

FILE: src/sha1_back.sv
module sha1_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  sha1_pkg::item_t                 item,
	output sha1_pkg::core_cmd_t             cmd,
	input  sha1_pkg::core_stat_t            stat,
	input  logic [4:0][31:0]                chain,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [sha1_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // digest_word, word_number
	output logic                            m_axis_tlast   // last_word
);
	import sha1_pkg::*;

	localparam logic [2:0] ST_TAKE  = 3'd0;
	localparam logic [2:0] ST_PAD   = 3'd1;
	localparam logic [2:0] ST_START = 3'd2;
	localparam logic [2:0] ST_WAIT  = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [2:0]  state_q;
	logic [60:0] cnt_q;
	logic [63:0] len_q;
	logic        pad_q;
	logic        sent80_q;
	logic        inlen_q;
	logic        pad_done_q;
	logic [2:0]  word_q;
	logic        out_valid_q;
	logic [31:0] out_word_q;
	logic [2:0]  out_num_q;
	logic        out_last_q;
	logic        len_now;
	logic [7:0]  pad_val;
	logic        out_load;

	assign item_ready    = (state_q == ST_TAKE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W - 35){1'b0}}, out_num_q, out_word_q};
	assign m_axis_tlast  = out_last_q;
	assign out_load      = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);

	// Next padding byte: the marker, zeros, then the bit count high byte first.
	always_comb begin
		len_now = inlen_q || (sent80_q && (cnt_q[5:0] == PAD_LEN_POS));
		if (!sent80_q) begin
			pad_val = PAD_BYTE;
		end else if (len_now) begin
			pad_val = len_q[63:56];
		end else begin
			pad_val = 8'h00;
		end
	end

	// Commands to the compression core.
	always_comb begin
		cmd.absorb   = 1'b0;
		cmd.byte_val = item.data;
		cmd.start    = 1'b0;
		cmd.reinit   = 1'b0;
		unique case (state_q)
			ST_TAKE: begin
				cmd.absorb = item_valid && !item.finish;
			end
			ST_PAD: begin
				cmd.absorb   = 1'b1;
				cmd.byte_val = pad_val;
			end
			ST_START: begin
				cmd.start = 1'b1;
			end
			ST_WAIT: begin
				cmd.start = 1'b0;
			end
			ST_EMIT: begin
				cmd.reinit = out_load && (word_q == LAST_WORD_NUM);
			end
			default: begin
				cmd.start = 1'b0;
			end
		endcase
	end

	// Sequencer: intake, padding, block starts and digest output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_TAKE;
			cnt_q      <= '0;
			pad_q      <= 1'b0;
			sent80_q   <= 1'b0;
			inlen_q    <= 1'b0;
			pad_done_q <= 1'b0;
			word_q     <= '0;
		end else begin
			unique case (state_q)
				ST_TAKE: begin
					if (item_valid) begin
						if (item.finish) begin
							pad_q    <= 1'b1;
							sent80_q <= 1'b0;
							inlen_q  <= 1'b0;
							state_q  <= ST_PAD;
						end else begin
							cnt_q <= cnt_q + 1'b1;
							if (cnt_q[5:0] == BLOCK_END) begin
								state_q <= ST_START;
							end
						end
					end
				end
				ST_PAD: begin
					sent80_q <= 1'b1;
					cnt_q    <= cnt_q + 1'b1;
					if (len_now) begin
						inlen_q <= 1'b1;
					end
					if (cnt_q[5:0] == BLOCK_END) begin
						state_q <= ST_START;
						if (len_now) begin
							pad_done_q <= 1'b1;
						end
					end
				end
				ST_START: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (stat.done) begin
						if (pad_done_q) begin
							state_q <= ST_EMIT;
						end else if (pad_q) begin
							state_q <= ST_PAD;
						end else begin
							state_q <= ST_TAKE;
						end
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						if (word_q == LAST_WORD_NUM) begin
							word_q     <= '0;
							cnt_q      <= '0;
							pad_q      <= 1'b0;
							sent80_q   <= 1'b0;
							inlen_q    <= 1'b0;
							pad_done_q <= 1'b0;
							state_q    <= ST_TAKE;
						end else begin
							word_q <= word_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_TAKE;
				end
			endcase
		end
	end

	// Bit count of the message, shifted out a byte at a time during padding.
	always_ff @(posedge clk) begin
		if (state_q == ST_TAKE && item_valid && item.finish) begin
			len_q <= {cnt_q, 3'b000};
		end else if (state_q == ST_PAD && len_now) begin
			len_q <= {len_q[55:0], 8'h00};
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_word_q <= chain[word_q];
			out_num_q  <= word_q;
			out_last_q <= (word_q == LAST_WORD_NUM);
		end
	end

	// New items are taken only while the core is idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TAKE) |-> !stat.busy)
		else $error("item taken while compressing");

	// Digest words go out only after a block boundary.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (cnt_q[5:0] == 6'd0) && pad_done_q)
		else $error("digest emitted mid block");

	// The marked beat carries the final word number.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_last_q) |-> (out_num_q == LAST_WORD_NUM))
		else $error("last beat with wrong word number");

endmodule

FILE: src/sha1_stream_hasher.sv
// Channel   Dir  Beat fields (tdata low bit up | tuser | tlast)
// s_axis    in   data_byte[7:0]             | kind  | -
// m_axis    out  digest_word[31:0], word_number[34:32], zero pad | - | last_word
//
// The back end absorbs each data byte as it takes it; each full 64-byte block
// then goes through the start, 80 rounds of the single round unit and the final add.
// A finish beat leads to padding that fills one or two blocks, then five
// output beats. A four-entry queue keeps taking input while the back end works.
// Reset loads the initial chaining value and clears the count and queue.
// While m_axis_tready is low the back end waits on the output register; once
// the last word is loaded it goes back to taking data bytes.
module sha1_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // data_byte
	input  logic        s_axis_tuser,   // kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // digest_word, word_number, zero pad
	output logic        m_axis_tlast    // last_word
);
	import sha1_pkg::*;

	logic             item_valid;
	logic             item_ready;
	item_t            item;
	core_cmd_t        cmd;
	core_stat_t       stat;
	logic [4:0][31:0] chain;

	// Front: accepts and classifies beats into the queue.
	sha1_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.item          (item)
	);

	// Back: intake, padding and output sequencing.
	sha1_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.item          (item),
		.cmd           (cmd),
		.stat          (stat),
		.chain         (chain),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// Compression rounds and chaining value.
	sha1_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.chain  (chain)
	);

endmodule
